// ----- sv/rational_accumulator_assert.svh -----
`ifndef RATIONAL_ACCUMULATOR_ASSERT_SVH
`define RATIONAL_ACCUMULATOR_ASSERT_SVH

// Immediate implication: cons must hold in the same cycle as ante.
`define RA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rational_accumulator check failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define RA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rational_accumulator check failed");

`endif

// ----- sv/ra_pkg.sv -----
package ra_pkg;

    localparam int VALUE_WIDTH_DEF = 32;

    // stream widths, fields packed from bit 0 and padded to bytes
    localparam int IN_W  = 72;
    localparam int OUT_W = 72;

    // internal arithmetic widths
    localparam int WIDE   = 64;   // magnitudes in gcd and divider
    localparam int PROD_W = 65;   // signed products and sums
    localparam int OPW    = 34;   // signed multiplier operands

    typedef enum logic [2:0] {
        MODE_LOAD = 3'd0,
        MODE_ADD  = 3'd1,
        MODE_SUB  = 3'd2,
        MODE_MUL  = 3'd3,
        MODE_DIV  = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_ZERO = 2'd1,
        ERR_OVF  = 2'd2
    } err_t;

    localparam logic [1:0] CMP_EQ = 2'b00;
    localparam logic [1:0] CMP_GT = 2'b01;
    localparam logic [1:0] CMP_LT = 2'b11;

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_RED_START = 9'b000000010,
        S_GCD       = 9'b000000100,
        S_DIV_N     = 9'b000001000,
        S_DIV_D     = 9'b000010000,
        S_RED_END   = 9'b000100000,
        S_MUL       = 9'b001000000,
        S_SEL       = 9'b010000000,
        S_DONE      = 9'b100000000
    } state_t;

endpackage

// ----- sv/ra_gcd.sv -----
// Binary (Stein) gcd, one shift or subtract per cycle. Both inputs nonzero.
module ra_gcd
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [ra_pkg::WIDE-1:0] a,
    input  logic [ra_pkg::WIDE-1:0] b,
    output logic                    done,
    output logic [ra_pkg::WIDE-1:0] g
);
    import ra_pkg::*;

    logic [WIDE-1:0] u_reg;
    logic [WIDE-1:0] v_reg;
    logic [5:0]      k_reg;
    logic            busy_reg;
    logic            done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && (u_reg == v_reg))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            u_reg <= a;
            v_reg <= b;
            k_reg <= '0;
        end
        else if (busy_reg && (u_reg != v_reg))
        begin
            if (!u_reg[0] && !v_reg[0])
            begin
                u_reg <= u_reg >> 1;
                v_reg <= v_reg >> 1;
                k_reg <= k_reg + 6'd1;
            end
            else if (!u_reg[0])
            begin
                u_reg <= u_reg >> 1;
            end
            else if (!v_reg[0])
            begin
                v_reg <= v_reg >> 1;
            end
            else if (u_reg > v_reg)
            begin
                u_reg <= (u_reg - v_reg) >> 1;
            end
            else
            begin
                v_reg <= (v_reg - u_reg) >> 1;
            end
        end
    end

    assign done = done_reg;
    assign g    = u_reg << k_reg;

endmodule

// ----- sv/ra_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
module ra_div
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [ra_pkg::WIDE-1:0] dividend,
    input  logic [ra_pkg::WIDE-1:0] divisor,
    output logic                    done,
    output logic [ra_pkg::WIDE-1:0] quotient
);
    import ra_pkg::*;

    localparam int CW = $clog2(WIDE);

    logic [WIDE:0]   rem_reg;
    logic [WIDE-1:0] quo_reg;
    logic [WIDE-1:0] dsr_reg;
    logic [CW-1:0]   cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [WIDE:0]   rem_sh;
    logic            fits;

    assign rem_sh = {rem_reg[WIDE-1:0], quo_reg[WIDE-1]};
    assign fits   = rem_sh >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(WIDE - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (rem_sh - {1'b0, dsr_reg}) : rem_sh;
            quo_reg <= {quo_reg[WIDE-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- sv/rational_accumulator.sv -----
// Flow: a zero operand denominator goes straight to the done state, where the result is
//   registered; otherwise up to two reductions (operand, then result), each a bit-serial
//   binary gcd and two divides by the gcd, with the four products on one multiplier
//   between them.
// Throughput: one item at a time; s_axis_tready is high only while idle.
// Reset (rst_n low, asynchronous): stored value 0/1, no result pending.
module rational_accumulator #(
    parameter int VALUE_WIDTH = ra_pkg::VALUE_WIDTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // [2:0] mode, [34:3] operand_numerator, [66:35] operand_denominator, rest zero
    input  logic [ra_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // [31:0] result_numerator, [62:32] result_denominator, [63] is_integer,
    // [64] equal_before, [66:65] compare_sign, [68:67] error_code, rest zero
    output logic [ra_pkg::OUT_W-1:0]  m_axis_tdata
);
    import ra_pkg::*;

    // bounds of the stored value
    localparam logic [WIDE-1:0] HI     = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;
    localparam logic [WIDE-1:0] LO_MAG = 64'd1 << (VALUE_WIDTH - 1);

    // ---------------------------------------------------------------
    // Input unpacking
    // ---------------------------------------------------------------
    logic [2:0]         in_mode;
    logic signed [31:0] in_num;
    logic signed [31:0] in_den;
    logic signed [WIDE-1:0] in_num_w;
    logic signed [WIDE-1:0] in_den_w;
    logic               in_accept;

    assign in_mode  = s_axis_tdata[2:0];
    assign in_num   = s_axis_tdata[34:3];
    assign in_den   = s_axis_tdata[66:35];
    assign in_num_w = WIDE'(in_num);
    assign in_den_w = WIDE'(in_den);

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    state_t state_reg, state_next;

    logic signed [VALUE_WIDTH-1:0] a_reg;          // stored numerator
    logic [VALUE_WIDTH-2:0]        b_reg;          // stored denominator
    logic [2:0]                    mode_reg;
    logic signed [OPW-1:0]         c_reg;          // reduced operand numerator
    logic [OPW-2:0]                d_reg;          // reduced operand denominator
    logic                          neg_reg;        // sign of fraction under reduction
    logic [WIDE-1:0]               mag_reg;        // |numerator| under reduction
    logic [WIDE-1:0]               den_reg;        // denominator under reduction
    logic [WIDE-1:0]               g_reg;
    logic                          phase_reg;      // 0 operand, 1 result
    logic [1:0]                    mul_idx_reg;
    logic signed [PROD_W-1:0]      p_reg [4];      // a*d, c*b, a*c, b*d
    logic [1:0]                    err_reg;
    logic                          eq_reg;
    logic [1:0]                    cmp_reg;
    logic                          out_valid_reg;
    logic [OUT_W-1:0]              out_data_reg;

    logic                          gcd_start_reg;
    logic                          div_start_reg;
    logic [WIDE-1:0]               div_dvd_reg;
    logic [WIDE-1:0]               div_dsr_reg;

    // ---------------------------------------------------------------
    // Shared units
    // ---------------------------------------------------------------
    logic            gcd_done;
    logic [WIDE-1:0] gcd_g;
    logic            div_done;
    logic [WIDE-1:0] div_q;

    ra_gcd u_gcd
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (gcd_start_reg),
        .a     (mag_reg),
        .b     (den_reg),
        .done  (gcd_done),
        .g     (gcd_g)
    );

    ra_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_dvd_reg),
        .divisor  (div_dsr_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // one multiplier, four products in turn
    logic signed [OPW-1:0]     mul_x;
    logic signed [OPW-1:0]     mul_y;
    logic signed [2*OPW-1:0]   prod_full;

    always_comb
    begin
        case (mul_idx_reg)
            2'd0:    begin mul_x = OPW'(a_reg); mul_y = OPW'(d_reg); end
            2'd1:    begin mul_x = c_reg;       mul_y = OPW'(b_reg); end
            2'd2:    begin mul_x = OPW'(a_reg); mul_y = c_reg;       end
            default: begin mul_x = OPW'(b_reg); mul_y = OPW'(d_reg); end
        endcase
    end

    assign prod_full = mul_x * mul_y;

    // ---------------------------------------------------------------
    // Mode selection after the products
    // ---------------------------------------------------------------
    logic signed [PROD_W-1:0] diff;
    logic signed [PROD_W-1:0] rn_sel;
    logic signed [PROD_W-1:0] rd_sel;
    logic                     sel_write;
    logic                     sel_divzero;
    logic [PROD_W-1:0]        rn_abs;
    logic [PROD_W-1:0]        rd_abs;

    assign diff = p_reg[0] - p_reg[1];

    always_comb
    begin
        rn_sel      = PROD_W'(c_reg);
        rd_sel      = PROD_W'(d_reg);
        sel_write   = 1'b1;
        sel_divzero = 1'b0;
        case (mode_reg)
            MODE_LOAD:
            begin
                rn_sel = PROD_W'(c_reg);
                rd_sel = PROD_W'(d_reg);
            end
            MODE_ADD:
            begin
                rn_sel = p_reg[0] + p_reg[1];
                rd_sel = p_reg[3];
            end
            MODE_SUB:
            begin
                rn_sel = diff;
                rd_sel = p_reg[3];
            end
            MODE_MUL:
            begin
                rn_sel = p_reg[2];
                rd_sel = p_reg[3];
            end
            MODE_DIV:
            begin
                rn_sel = p_reg[0];
                rd_sel = p_reg[1];   // b*c
                if (c_reg == '0)
                begin
                    sel_write   = 1'b0;
                    sel_divzero = 1'b1;
                end
            end
            default:
            begin
                sel_write = 1'b0;
            end
        endcase
    end

    assign rn_abs = rn_sel[PROD_W-1] ? -rn_sel : rn_sel;
    assign rd_abs = rd_sel[PROD_W-1] ? -rd_sel : rd_sel;

    // ---------------------------------------------------------------
    // Writeback of a reduced result, with overflow wrap
    // ---------------------------------------------------------------
    logic [WIDE-1:0]        res_signed;
    logic                   ovf;
    logic [VALUE_WIDTH-2:0] den_trunc;

    assign res_signed = neg_reg ? -mag_reg : mag_reg;
    assign ovf        = (neg_reg ? (mag_reg > LO_MAG) : (mag_reg > HI)) || (den_reg > HI);
    assign den_trunc  = den_reg[VALUE_WIDTH-2:0];

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    logic out_load;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == S_DONE) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_accept)
                    state_next = (in_den == '0) ? S_DONE : S_RED_START;
            S_RED_START:
                state_next = (mag_reg == '0) ? S_RED_END : S_GCD;
            S_GCD:
                if (gcd_done)
                    state_next = S_DIV_N;
            S_DIV_N:
                if (div_done)
                    state_next = S_DIV_D;
            S_DIV_D:
                if (div_done)
                    state_next = S_RED_END;
            S_RED_END:
                state_next = phase_reg ? S_DONE : S_MUL;
            S_MUL:
                if (mul_idx_reg == 2'd3)
                    state_next = S_SEL;
            S_SEL:
                state_next = sel_write ? S_RED_START : S_DONE;
            S_DONE:
                if (out_load)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            gcd_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            a_reg         <= '0;
            b_reg         <= (VALUE_WIDTH-1)'(1);
        end
        else
        begin
            state_reg     <= state_next;
            gcd_start_reg <= (state_reg == S_RED_START) && (mag_reg != '0);
            div_start_reg <= ((state_reg == S_GCD) && gcd_done)
                          || ((state_reg == S_DIV_N) && div_done);
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            if ((state_reg == S_RED_END) && phase_reg)
            begin
                a_reg <= res_signed[VALUE_WIDTH-1:0];
                b_reg <= (den_trunc == '0) ? (VALUE_WIDTH-1)'(1) : den_trunc;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (in_accept)
                begin
                    mode_reg  <= in_mode;
                    err_reg   <= (in_den == '0) ? ERR_ZERO : ERR_NONE;
                    eq_reg    <= 1'b0;
                    cmp_reg   <= CMP_EQ;
                    phase_reg <= 1'b0;
                    neg_reg   <= in_num[31] ^ in_den[31];
                    mag_reg   <= in_num[31] ? -in_num_w : in_num_w;
                    den_reg   <= in_den[31] ? -in_den_w : in_den_w;
                end
            S_RED_START:
                if (mag_reg == '0)
                begin
                    // zero numerator forces denominator 1
                    den_reg <= WIDE'(1);
                    neg_reg <= 1'b0;
                end
            S_GCD:
                if (gcd_done)
                begin
                    g_reg       <= gcd_g;
                    div_dvd_reg <= mag_reg;
                    div_dsr_reg <= gcd_g;
                end
            S_DIV_N:
                if (div_done)
                begin
                    mag_reg     <= div_q;
                    div_dvd_reg <= den_reg;
                    div_dsr_reg <= g_reg;
                end
            S_DIV_D:
                if (div_done)
                    den_reg <= div_q;
            S_RED_END:
                if (!phase_reg)
                begin
                    c_reg       <= neg_reg ? -OPW'(mag_reg) : OPW'(mag_reg);
                    d_reg       <= den_reg[OPW-2:0];
                    mul_idx_reg <= 2'd0;
                end
                else if (ovf)
                begin
                    err_reg <= ERR_OVF;
                end
            S_MUL:
            begin
                p_reg[mul_idx_reg] <= prod_full[PROD_W-1:0];
                mul_idx_reg        <= mul_idx_reg + 2'd1;
            end
            S_SEL:
            begin
                eq_reg    <= (diff == '0);
                cmp_reg   <= diff[PROD_W-1] ? CMP_LT : ((diff == '0) ? CMP_EQ : CMP_GT);
                phase_reg <= 1'b1;
                if (sel_divzero)
                    err_reg <= ERR_ZERO;
                neg_reg   <= rn_sel[PROD_W-1] ^ rd_sel[PROD_W-1];
                mag_reg   <= rn_abs[WIDE-1:0];
                den_reg   <= rd_abs[WIDE-1:0];
            end
            S_DONE:
                if (out_load)
                    out_data_reg <= {3'b000, err_reg, cmp_reg, eq_reg,
                                     (b_reg == (VALUE_WIDTH-1)'(1)),
                                     31'(b_reg), 32'(a_reg)};
            default:
            begin
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ----- sv/ra_chk.sv -----
module ra_chk
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     s_axis_tvalid,
    input logic                     s_axis_tready,
    input logic [ra_pkg::IN_W-1:0]  s_axis_tdata,
    input logic                     m_axis_tvalid,
    input logic                     m_axis_tready,
    input logic [ra_pkg::OUT_W-1:0] m_axis_tdata
);
`include "rational_accumulator_assert.svh"

    // a stalled result holds
    `RA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // one item at a time: busy right after a transfer in
    `RA_ASSERT_NEXT(a_busy_after_in, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // integer flag agrees with the denominator
    `RA_ASSERT_IMPL(a_int_flag, m_axis_tvalid, m_axis_tdata[63] == (m_axis_tdata[62:32] == 31'd1))

    // equal values compare as zero
    `RA_ASSERT_IMPL(a_eq_cmp, m_axis_tvalid && m_axis_tdata[64], m_axis_tdata[66:65] == 2'b00)

endmodule

bind rational_accumulator ra_chk u_ra_chk (.*);

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import ra_pkg::*;

    // ------------------------------------------------------------------
    // Clock, reset and the two stream groups
    // ------------------------------------------------------------------
    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    // [2:0] mode, [34:3] operand_numerator, [66:35] operand_denominator, rest zero
    logic [IN_W-1:0]   s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    // [31:0] result_numerator, [62:32] result_denominator, [63] is_integer,
    // [64] equal_before, [66:65] compare_sign, [68:67] error_code, rest zero
    logic [OUT_W-1:0]  m_axis_tdata;

    rational_accumulator uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Predictor: one reduced fraction, exact wide arithmetic
    // ------------------------------------------------------------------
    // fields from the top bit down, matching the result tdata layout
    typedef struct packed {
        err_t               err;
        logic [1:0]         cmp;
        logic               eq;
        logic               is_int;
        logic [30:0]        den;
        logic signed [31:0] num;
    } fraction_result_t;

    localparam longint VMAX = 64'sd2147483647;
    localparam longint VMIN = -64'sd2147483648;

    longint acc_num;
    longint acc_den;

    fraction_result_t expected_fractions[$];

    int errors;
    int items_sent;
    int results_seen;
    int ovf_seen;
    int zero_seen;

    // idle percentages for the two sides
    int send_idle_pct;
    int recv_stall_pct;

    function automatic longint unsigned euclid(longint unsigned a, longint unsigned b);
        longint unsigned t;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    // sign to numerator, divide out the gcd; magnitudes stay below 2^63
    task automatic normalize(inout longint n, inout longint d);
        longint unsigned mag;
        longint g;
        if (d < 0)
        begin
            n = -n;
            d = -d;
        end
        if (n == 0)
            d = 1;
        else
        begin
            mag = (n < 0) ? longint'(-n) : n;
            g = longint'(euclid(mag, d));
            n = n / g;
            d = d / g;
        end
    endtask

    task automatic predict_step(input logic [2:0] op, input logic signed [31:0] on,
                                input logic signed [31:0] od);
        longint c, d, a, b, diff, rn, rd;
        bit wr;
        fraction_result_t r;
        c = on;
        d = od;
        a = acc_num;
        b = acc_den;
        r = '0;
        r.err = ERR_NONE;
        if (d == 0)
            r.err = ERR_ZERO;
        else
        begin
            normalize(c, d);
            diff = a * d - c * b;
            r.cmp = (diff > 0) ? CMP_GT : (diff < 0) ? CMP_LT : CMP_EQ;
            r.eq = (diff == 0);
            wr = 1'b1;
            rn = a;
            rd = b;
            case (op)
                MODE_LOAD: begin rn = c; rd = d; end
                MODE_ADD:  begin rn = a * d + c * b; rd = b * d; end
                MODE_SUB:  begin rn = diff; rd = b * d; end
                MODE_MUL:  begin rn = a * c; rd = b * d; end
                MODE_DIV:
                begin
                    if (c == 0)
                    begin
                        r.err = ERR_ZERO;
                        wr = 1'b0;
                    end
                    else
                    begin
                        rn = a * d;
                        rd = b * c;
                    end
                end
                default: wr = 1'b0;
            endcase
            if (wr)
            begin
                normalize(rn, rd);
                if (rn < VMIN || rn > VMAX || rd > VMAX)
                begin
                    // keep low bits; a zero denominator becomes one
                    r.err = ERR_OVF;
                    rn = longint'($signed(rn[31:0]));
                    rd = rd & VMAX;
                    if (rd == 0)
                        rd = 1;
                end
                acc_num = rn;
                acc_den = rd;
            end
        end
        r.num = acc_num[31:0];
        r.den = acc_den[30:0];
        r.is_int = (acc_den == 1);
        expected_fractions.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Sender: one transfer per call, drives at the falling edge
    // ------------------------------------------------------------------
    task automatic send_fraction(input logic [2:0] op, input logic signed [31:0] on,
                                 input logic signed [31:0] od);
        // the block is busy after a transfer, so this costs nothing
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        s_axis_tdata  <= {5'b0, od, on, op};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_step(op, on, od);
        items_sent++;
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain;
        int guard;
        guard = 0;
        while (expected_fractions.size() != 0 && guard < 200000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (600) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result checker and receiver stalls
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        fraction_result_t got;
        fraction_result_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[68:0];
            results_seen++;
            if (expected_fractions.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end
            else
            begin
                exp_r = expected_fractions.pop_front();
                if (got.err == ERR_OVF)
                    ovf_seen++;
                if (got.err == ERR_ZERO)
                    zero_seen++;
                if (got.num !== exp_r.num)
                begin
                    $display("%0t: numerator exp %0d got %0d", $time, exp_r.num, got.num);
                    errors++;
                end
                if (got.den !== exp_r.den)
                begin
                    $display("%0t: denominator exp %0d got %0d", $time, exp_r.den, got.den);
                    errors++;
                end
                if (got.is_int !== exp_r.is_int)
                begin
                    $display("%0t: is_integer exp %b got %b", $time, exp_r.is_int, got.is_int);
                    errors++;
                end
                if (got.eq !== exp_r.eq)
                begin
                    $display("%0t: equal_before exp %b got %b", $time, exp_r.eq, got.eq);
                    errors++;
                end
                if (got.cmp !== exp_r.cmp)
                begin
                    $display("%0t: compare_sign exp %b got %b", $time, exp_r.cmp, got.cmp);
                    errors++;
                end
                if (got.err !== exp_r.err)
                begin
                    $display("%0t: error_code exp %0d got %0d", $time, exp_r.err, got.err);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Random operand helpers
    // ------------------------------------------------------------------
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(5))
            0: return $signed($urandom);
            1: return $signed($urandom_range(20)) - 10;
            2: return $signed($urandom_range(2000)) - 1000;
            3: return $urandom_range(1) ? 32'sh7fffffff - $urandom_range(3)
                                        : 32'sh80000000 + $urandom_range(3);
            4: return $signed($urandom) >>> $urandom_range(31);
            default: return $signed($urandom_range(65535)) - 32768;
        endcase
    endfunction

    function automatic logic [2:0] pick_mode();
        int k;
        k = $urandom_range(99);
        if (k < 15) return MODE_LOAD;
        if (k < 37) return MODE_ADD;
        if (k < 59) return MODE_SUB;
        if (k < 78) return MODE_MUL;
        if (k < 96) return MODE_DIV;
        return 3'($urandom_range(7, 5));
    endfunction

    task automatic random_items(input int count);
        logic signed [31:0] dv;
        for (int i = 0; i < count; i++)
        begin
            dv = pick_value();
            if ($urandom_range(49) == 0)
                dv = 0;
            send_fraction(pick_mode(), pick_value(), dv);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed;
        send_fraction(MODE_ADD, 32'sd0, 32'sd1);             // reset value compare
        send_fraction(MODE_LOAD, 32'sd6, -32'sd4);            // sign moves, reduced
        send_fraction(MODE_ADD, 32'sd1, 32'sd2);
        send_fraction(MODE_SUB, -32'sd3, 32'sd7);
        send_fraction(MODE_MUL, 32'sd14, -32'sd5);
        send_fraction(MODE_DIV, 32'sd2, 32'sd3);
        send_fraction(MODE_DIV, 32'sd0, 32'sd9);              // divide by zero
        send_fraction(MODE_ADD, 32'sd5, 32'sd0);              // zero denominator
        send_fraction(3'd5, 32'sd1, 32'sd1);                  // unused modes
        send_fraction(3'd7, -32'sd1, 32'sd1);
        send_fraction(MODE_LOAD, 32'sh7fffffff, 32'sd1);
        send_fraction(MODE_ADD, 32'sh7fffffff, 32'sd1);        // numerator overflow
        send_fraction(MODE_LOAD, 32'sh80000000, 32'sh80000000);
        send_fraction(MODE_LOAD, 32'sh80000000, -32'sd1);     // negated min overflows
        send_fraction(MODE_LOAD, 32'sd1, 32'sh7fffffff);
        send_fraction(MODE_MUL, 32'sd1, 32'sh7ffffffe);       // denominator overflow
        send_fraction(MODE_LOAD, 32'sd0, 32'sh80000000);      // zero numerator
        send_fraction(MODE_SUB, 32'sh80000000, 32'sh7fffffff);
        send_fraction(MODE_DIV, 32'sh7fffffff, 32'sh80000000);
        send_fraction(MODE_MUL, 32'sh80000000, 32'sd3);
        send_fraction(3'd6, 32'sd0, 32'sd0);
        send_fraction(MODE_LOAD, 32'sd5, 32'sd5);
        send_fraction(MODE_SUB, 32'sd1, 32'sd1);              // equal, exact zero
    endtask

    task automatic test_no_idle;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_items(500);
    endtask

    task automatic test_sender_idle;
        send_idle_pct = 52;
        recv_stall_pct = 0;
        random_items(480);
        // hold off until the block has emptied, then resume
        drain();
        random_items(20);
    endtask

    task automatic test_receiver_stall;
        send_idle_pct = 0;
        recv_stall_pct = 52;
        random_items(480);
    endtask

    task automatic test_both_idle;
        send_idle_pct = 27;
        recv_stall_pct = 27;
        random_items(450);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        ovf_seen = 0;
        zero_seen = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        acc_num = 0;
        acc_den = 1;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_no_idle();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        drain();

        if (expected_fractions.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_fractions.size());
            errors++;
        end
        $display("Sent %0d operations over four idle patterns, checked %0d results",
                 items_sent, results_seen);
        $display("(%0d overflows, %0d zero-divisor cases)", ovf_seen, zero_seen);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // worst case per item plus stalls, taken several times over
    initial
    begin
        #60000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ----- rational_accumulator.f -----
+incdir+sv
sv/ra_pkg.sv
sv/ra_gcd.sv
sv/ra_div.sv
sv/rational_accumulator.sv
sv/ra_chk.sv
dv/testbench.sv
